// ===== src/stx_etx_frame_parser_macros.svh =====
// Assertion macros shared by the frame parser RTL.
`ifndef STX_ETX_FRAME_PARSER_MACROS_SVH
`define STX_ETX_FRAME_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define STXP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define STXP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/stxp_pkg.sv =====
// Shared types and codes of the frame parser.
package stxp_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_OWN_DEV_ID   = 2'd2;

  localparam logic [7:0]  START_MARKER_RST = 8'h02;
  localparam logic [7:0]  END_MARKER_RST   = 8'h03;
  localparam logic [15:0] OWN_DEV_ID_RST   = 16'h0000;

  // Verdict codes
  localparam logic [1:0] VERDICT_OK       = 2'd0;
  localparam logic [1:0] VERDICT_BAD_DELIM = 2'd1;
  localparam logic [1:0] VERDICT_ID_MISM  = 2'd2;

  // Item kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic [7:0]  start_marker;
    logic [7:0]  end_marker;
    logic [15:0] own_device_id;
  } cfg_t;

endpackage

// ===== src/stxp_regs.sv =====
// Configuration registers of the frame parser behind an APB-style port.
module stxp_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output stxp_pkg::cfg_t     cfg_o
);

  logic       wr_en;
  logic [1:0] reg_idx;
  stxp_pkg::cfg_t cfg_q, cfg_d;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        stxp_pkg::REG_START_MARKER: cfg_d.start_marker  = pwdata[7:0];
        stxp_pkg::REG_END_MARKER:   cfg_d.end_marker    = pwdata[7:0];
        stxp_pkg::REG_OWN_DEV_ID:   cfg_d.own_device_id = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker  <= stxp_pkg::START_MARKER_RST;
      cfg_q.end_marker    <= stxp_pkg::END_MARKER_RST;
      cfg_q.own_device_id <= stxp_pkg::OWN_DEV_ID_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      stxp_pkg::REG_START_MARKER: prdata = {24'd0, cfg_q.start_marker};
      stxp_pkg::REG_END_MARKER:   prdata = {24'd0, cfg_q.end_marker};
      stxp_pkg::REG_OWN_DEV_ID:   prdata = {16'd0, cfg_q.own_device_id};
      default:                    prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/stx_etx_frame_parser.sv =====
// Top level of the STX/ETX delimited frame parser.
//
// Input channel: one received byte per item (rx_byte_i) with end_of_frame_i
// marking the last byte of a frame. An item moves when in_valid_i is high
// and in_stall_o is low.
// Output channel: zero or one result item per input item, held in an output
// register; it moves when out_valid_o is high and out_stall_i is low.
// A payload byte leaves as a kind-0 item; the flagged byte leaves as a
// kind-1 verdict item with final_item_o set.
// A result is registered in the output register when its input item is accepted.
// Throughput: one input item per cycle unless stalled; the phase update and
// the marker and id compares sit between the parse state and output register.
// When the receiver stalls, the output register holds its item and the input
// stalls only if that register is full and not being emptied this cycle.
// Reset empties the output register, returns the parser to waiting for a
// start byte with the header view cleared, and loads the marker registers
// with 0x02 / 0x03 and the device id with zero.
// Configuration registers: start marker at 0x0, end marker at 0x4, own
// device id at 0x8; write only while no item is in flight.
`include "stx_etx_frame_parser_macros.svh"

module stx_etx_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        end_of_frame_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        item_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [15:0] frame_device_id_o,
  output logic [7:0]  frame_opcode_o,
  output logic [15:0] payload_length_o,
  output logic [1:0]  verdict_o,
  output logic        final_item_o
);

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_ID_HI   = 3'd1;
  localparam logic [2:0] PH_ID_LO   = 3'd2;
  localparam logic [2:0] PH_OPCODE  = 3'd3;
  localparam logic [2:0] PH_LEN_HI  = 3'd4;
  localparam logic [2:0] PH_LEN_LO  = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic [2:0] PH_DONE    = 3'd7;

  stxp_pkg::cfg_t cfg;

  logic [2:0]  phase_q, phase_d;
  logic        start_ok_q, start_ok_d;
  logic [15:0] dev_id_q, dev_id_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [15:0] length_q, length_d;
  logic [15:0] remain_q, remain_d;

  logic        out_valid_q, out_valid_d;
  logic        kind_q, kind_d;
  logic [7:0]  pbyte_q, pbyte_d;
  logic [15:0] out_id_q, out_id_d;
  logic [7:0]  out_op_q, out_op_d;
  logic [15:0] out_len_q, out_len_d;
  logic [1:0]  verdict_q, verdict_d;
  logic        final_q, final_d;

  logic in_acc;
  logic emit;
  logic hdr_done;
  logic start_good;

  stxp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Accept while the output register is free or being emptied
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign hdr_done   = (phase_q == PH_PAYLOAD) || (phase_q == PH_DONE);
  assign start_good = (phase_q != PH_START) && start_ok_q;

  // Parse one byte
  always_comb begin
    phase_d    = phase_q;
    start_ok_d = start_ok_q;
    dev_id_d   = dev_id_q;
    opcode_d   = opcode_q;
    length_d   = length_q;
    remain_d   = remain_q;
    emit       = 1'b0;
    kind_d     = stxp_pkg::KIND_PAYLOAD;
    pbyte_d    = 8'd0;
    out_id_d   = dev_id_q;
    out_op_d   = opcode_q;
    out_len_d  = length_q;
    verdict_d  = stxp_pkg::VERDICT_OK;
    final_d    = 1'b0;
    if (in_acc) begin
      if (end_of_frame_i) begin
        // close the frame with its verdict
        emit    = 1'b1;
        kind_d  = stxp_pkg::KIND_VERDICT;
        final_d = 1'b1;
        if (phase_q == PH_START) begin
          dev_id_d  = 16'd0;
          opcode_d  = 8'd0;
          length_d  = 16'd0;
          out_id_d  = 16'd0;
          out_op_d  = 8'd0;
          out_len_d = 16'd0;
        end
        if (!start_good || (rx_byte_i != cfg.end_marker) || !hdr_done) begin
          verdict_d = stxp_pkg::VERDICT_BAD_DELIM;
        end else if (dev_id_q != cfg.own_device_id) begin
          verdict_d = stxp_pkg::VERDICT_ID_MISM;
        end
        phase_d    = PH_START;
        start_ok_d = 1'b0;
        remain_d   = 16'd0;
      end else begin
        unique case (phase_q)
          PH_START: begin
            start_ok_d = (rx_byte_i == cfg.start_marker);
            dev_id_d   = 16'd0;
            opcode_d   = 8'd0;
            length_d   = 16'd0;
            remain_d   = 16'd0;
            phase_d    = PH_ID_HI;
          end
          PH_ID_HI: begin
            dev_id_d = {rx_byte_i, 8'd0};
            phase_d  = PH_ID_LO;
          end
          PH_ID_LO: begin
            dev_id_d = {dev_id_q[15:8], rx_byte_i};
            phase_d  = PH_OPCODE;
          end
          PH_OPCODE: begin
            opcode_d = rx_byte_i;
            phase_d  = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            length_d = {rx_byte_i, 8'd0};
            phase_d  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            length_d = {length_q[15:8], rx_byte_i};
            remain_d = {length_q[15:8], rx_byte_i};
            phase_d  = ({length_q[15:8], rx_byte_i} != 16'd0) ? PH_PAYLOAD : PH_DONE;
          end
          PH_PAYLOAD: begin
            // pass the payload byte on
            emit     = 1'b1;
            pbyte_d  = rx_byte_i;
            remain_d = remain_q - 16'd1;
            if (remain_q == 16'd1) begin
              phase_d = PH_DONE;
            end
          end
          PH_DONE: ; // drop extra bytes
          default: ;
        endcase
      end
    end
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      start_ok_q  <= 1'b0;
      dev_id_q    <= 16'd0;
      opcode_q    <= 8'd0;
      length_q    <= 16'd0;
      remain_q    <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      start_ok_q  <= start_ok_d;
      dev_id_q    <= dev_id_d;
      opcode_q    <= opcode_d;
      length_q    <= length_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      kind_q    <= kind_d;
      pbyte_q   <= pbyte_d;
      out_id_q  <= out_id_d;
      out_op_q  <= out_op_d;
      out_len_q <= out_len_d;
      verdict_q <= verdict_d;
      final_q   <= final_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign item_kind_o       = kind_q;
  assign payload_byte_o    = pbyte_q;
  assign frame_device_id_o = out_id_q;
  assign frame_opcode_o    = out_op_q;
  assign payload_length_o  = out_len_q;
  assign verdict_o         = verdict_q;
  assign final_item_o      = final_q;

  `STXP_ASSERT(a_eof_gives_verdict, in_acc && end_of_frame_i |=> out_valid_o && item_kind_o && final_item_o && (phase_q == PH_START), "flagged byte did not yield a verdict item")
  `STXP_ASSERT(a_payload_emits, in_acc && !end_of_frame_i && (phase_q == PH_PAYLOAD) |=> out_valid_o && !item_kind_o && (payload_byte_o == $past(rx_byte_i)), "payload byte not passed on")
  `STXP_ASSERT(a_remain_tracks_phase, ((phase_q != PH_DONE) || (remain_q == 16'd0)) && ((phase_q != PH_PAYLOAD) || (remain_q != 16'd0)), "payload count out of step with phase")
  `STXP_ASSERT(a_payload_item_fields, out_valid_o && !item_kind_o |-> !final_item_o && (verdict_o == stxp_pkg::VERDICT_OK), "payload item carries verdict fields")
  `STXP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && (phase_q == PH_START), "parser not idle in reset")

endmodule
